### hdl/window_size_escape_extractor_macros.svh
// ----------------------------------------------------------------------------
// Window size escape extractor: assertion macros
// Concurrent assertion wrappers; compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef WINDOW_SIZE_ESCAPE_EXTRACTOR_MACROS_SVH
`define WINDOW_SIZE_ESCAPE_EXTRACTOR_MACROS_SVH

`ifndef SYNTHESIS
// ante implies cons in the same cycle
`define WSEE_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);
// ante implies cons in the next cycle
`define WSEE_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define WSEE_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg)
`define WSEE_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

### hdl/wsee_pkg.sv
// ----------------------------------------------------------------------------
// Window size escape extractor: package
// Shared types, codes and constants for the front end, queue and back end.
// ----------------------------------------------------------------------------
`default_nettype none

package wsee_pkg;

    localparam int unsigned JOB_BYTES = 11;

    typedef logic [7:0] byte_t;
    typedef logic [3:0] pos_t;

    localparam byte_t ESC_MARK   = 8'hFF;
    localparam byte_t ESC_LETTER = 8'h73;
    localparam byte_t STRIP_MASK = 8'h7F;
    localparam pos_t  PREFIX_LEN = 4'd4;
    localparam pos_t  SEQ_LAST   = 4'd11;

    typedef enum logic {
        OP_DATA  = 1'b0,
        OP_FLUSH = 1'b1
    } opcode_t;

    typedef enum logic {
        KIND_DATA   = 1'b0,
        KIND_WINDOW = 1'b1
    } kind_t;

    // register index (paddr[2])
    localparam logic REG_STRIP_HIGH_BIT = 1'b0;

    // One queue entry: all results caused by one accepted input word.
    // Data job: bytes[0..cnt-1] go out in order.
    // Window job: cnt is 1, bytes[0..7] are the eight size bytes.
    typedef struct packed {
        kind_t                       kind;
        pos_t                        cnt;
        logic [JOB_BYTES-1:0][7:0]   bytes;
    } job_t;

    function automatic byte_t prefix_byte(input pos_t pos);
        prefix_byte = (pos < 4'd2) ? ESC_MARK : ESC_LETTER;
    endfunction

endpackage

`default_nettype wire

### hdl/window_size_escape_extractor.sv
// Throughput: one input word per cycle while the job queue is not full; the back
// end emits one result per cycle unless m_tready stalls it, so a word causing n
// results holds the back end until all n are out, and the job queue (QUEUE_DEPTH
// jobs) absorbs the difference before s_tready drops.
// Reset: synchronous active-low aresetn clears match state, queue, output
// valid and strip_high_bit; no clearing pass, ready the cycle after reset.
// ----------------------------------------------------------------------------
// Window size escape extractor: top level
// Removes the in-band window size escape from a byte stream and reports it.
// ----------------------------------------------------------------------------
`default_nettype none

`include "window_size_escape_extractor_macros.svh"

module window_size_escape_extractor #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    // input stream
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [7:0]   s_tdata,   // [7:0] in_byte
    input  wire logic         s_tuser,   // [0] opcode
    // result stream
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [71:0]       m_tdata,   // [7:0] out_byte, [23:8] window_rows,
                                         // [39:24] window_cols,
                                         // [55:40] window_xpixels,
                                         // [71:56] window_ypixels
    output logic              m_tuser,   // [0] kind
    output logic              m_tlast,   // last_of_run
    // configuration
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [2:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    logic             strip_reg;
    logic             s_accept;
    logic             q_full;
    logic             q_push;
    logic             q_pop;
    logic             head_valid;
    wsee_pkg::job_t   front_job;
    wsee_pkg::job_t   head_job;
    wsee_pkg::pos_t   match_pos;

    // ---- configuration
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            strip_reg <= 1'b0;
        end else if (psel && penable && pwrite && pready
                     && paddr[2] == wsee_pkg::REG_STRIP_HIGH_BIT) begin
            strip_reg <= pwdata[0];
        end
    end

    assign prdata = (paddr[2] == wsee_pkg::REG_STRIP_HIGH_BIT) ? {31'd0, strip_reg} : 32'd0;

    // ---- front / queue / back
    assign s_tready = !q_full;
    assign s_accept = s_tvalid && s_tready;

    wsee_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_accept),
        .opcode    (wsee_pkg::opcode_t'(s_tuser)),
        .in_byte   (s_tdata),
        .job       (front_job),
        .push      (q_push),
        .match_pos (match_pos)
    );

    wsee_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_job   (front_job),
        .pop        (q_pop),
        .head_job   (head_job),
        .head_valid (head_valid),
        .full       (q_full)
    );

    wsee_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .head_job       (head_job),
        .head_valid     (head_valid),
        .strip_high_bit (strip_reg),
        .pop            (q_pop),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .m_tlast        (m_tlast)
    );

    // ---- assertions
    `WSEE_ASSERT_NOW(a_window_is_last, aclk, aresetn, m_tvalid && m_tuser, m_tlast, "window word without tlast")
    `WSEE_ASSERT_NEXT(a_flush_clears, aclk, aresetn, s_accept && s_tuser, match_pos == 4'd0, "flush left match state")
    `WSEE_ASSERT_NOW(a_ready_only_full, aclk, aresetn, !s_tready, head_valid && !q_push, "stall without full queue")

endmodule

`default_nettype wire

### hdl/wsee_front.sv
// ----------------------------------------------------------------------------
// Window size escape extractor: front end
// Tracks the escape match, holds size bytes and turns each input word into
// one job describing the results it causes.
// ----------------------------------------------------------------------------
`default_nettype none

module wsee_front (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 in_valid,
    input  wire wsee_pkg::opcode_t    opcode,
    input  wire wsee_pkg::byte_t      in_byte,
    output wsee_pkg::job_t            job,
    output logic                      push,
    output wsee_pkg::pos_t            match_pos
);

    wsee_pkg::pos_t  match_pos_reg;
    wsee_pkg::pos_t  match_pos_next;
    wsee_pkg::byte_t window_reg [8];
    logic            wr_en;
    logic [2:0]      wr_idx;

    assign wr_idx    = 3'(match_pos_reg - wsee_pkg::PREFIX_LEN);
    assign match_pos = match_pos_reg;
    assign push      = in_valid && (job.cnt != 4'd0);

    always_comb begin
        job            = '0;
        job.kind       = wsee_pkg::KIND_DATA;
        match_pos_next = match_pos_reg;
        wr_en          = 1'b0;
        if (opcode == wsee_pkg::OP_FLUSH) begin
            // held bytes are the prefix, then size bytes in arrival order
            job.cnt      = match_pos_reg;
            job.bytes[0] = wsee_pkg::ESC_MARK;
            job.bytes[1] = wsee_pkg::ESC_MARK;
            job.bytes[2] = wsee_pkg::ESC_LETTER;
            job.bytes[3] = wsee_pkg::ESC_LETTER;
            for (int k = 0; k < 7; k++) begin
                job.bytes[4 + k] = window_reg[k];
            end
            match_pos_next = '0;
        end else if (match_pos_reg >= wsee_pkg::PREFIX_LEN) begin
            wr_en = 1'b1;
            if (match_pos_reg == wsee_pkg::SEQ_LAST) begin
                job.kind = wsee_pkg::KIND_WINDOW;
                job.cnt  = 4'd1;
                for (int k = 0; k < 7; k++) begin
                    job.bytes[k] = window_reg[k];
                end
                job.bytes[7]   = in_byte;
                match_pos_next = '0;
            end else begin
                match_pos_next = match_pos_reg + 4'd1;
            end
        end else if (in_byte == wsee_pkg::prefix_byte(match_pos_reg)) begin
            match_pos_next = match_pos_reg + 4'd1;
        end else begin
            // false prefix: rescan of the held bytes folded into fixed outcomes
            unique case (match_pos_reg[1:0])
                2'd0: begin
                    job.cnt        = 4'd1;
                    job.bytes[0]   = in_byte;
                    match_pos_next = '0;
                end
                2'd1: begin
                    job.cnt        = 4'd2;
                    job.bytes[0]   = wsee_pkg::ESC_MARK;
                    job.bytes[1]   = in_byte;
                    match_pos_next = '0;
                end
                2'd2: begin
                    job.bytes[0] = wsee_pkg::ESC_MARK;
                    if (in_byte == wsee_pkg::ESC_MARK) begin
                        job.cnt        = 4'd1;
                        match_pos_next = 4'd2;
                    end else begin
                        job.cnt        = 4'd3;
                        job.bytes[1]   = wsee_pkg::ESC_MARK;
                        job.bytes[2]   = in_byte;
                        match_pos_next = '0;
                    end
                end
                2'd3: begin
                    job.bytes[0] = wsee_pkg::ESC_MARK;
                    job.bytes[1] = wsee_pkg::ESC_MARK;
                    job.bytes[2] = wsee_pkg::ESC_LETTER;
                    if (in_byte == wsee_pkg::ESC_MARK) begin
                        job.cnt        = 4'd3;
                        match_pos_next = 4'd1;
                    end else begin
                        job.cnt        = 4'd4;
                        job.bytes[3]   = in_byte;
                        match_pos_next = '0;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            match_pos_reg <= '0;
        end else if (in_valid) begin
            match_pos_reg <= match_pos_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && wr_en) begin
            window_reg[wr_idx] <= in_byte;
        end
    end

endmodule

`default_nettype wire

### hdl/wsee_queue.sv
// ----------------------------------------------------------------------------
// Window size escape extractor: job queue
// Small FIFO of jobs between the front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module wsee_queue #(
    parameter int unsigned DEPTH = 4
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              push,
    input  wire wsee_pkg::job_t    push_job,
    input  wire logic              pop,
    output wsee_pkg::job_t         head_job,
    output logic                   head_valid,
    output logic                   full
);

    localparam int unsigned PW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);

    wsee_pkg::job_t  mem [DEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   rd_ptr_reg;
    logic [CW-1:0]   count_reg;

    assign head_job   = mem[rd_ptr_reg];
    assign head_valid = (count_reg != '0);
    assign full       = (count_reg == CW'(DEPTH));

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

### hdl/wsee_back.sv
// ----------------------------------------------------------------------------
// Window size escape extractor: back end
// Walks the head job one result per unstalled cycle into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module wsee_back (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire wsee_pkg::job_t    head_job,
    input  wire logic              head_valid,
    input  wire logic              strip_high_bit,
    output logic                   pop,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [71:0]            m_tdata,
    output logic                   m_tuser,
    output logic                   m_tlast
);

    wsee_pkg::pos_t  idx_reg;
    wsee_pkg::byte_t cur_byte;
    wsee_pkg::byte_t data_byte;
    logic            load;
    logic            last_res;
    logic            out_valid_reg;
    logic [71:0]     tdata_reg;
    logic            tuser_reg;
    logic            tlast_reg;
    logic [71:0]     tdata_next;

    assign load      = head_valid && (!out_valid_reg || m_tready);
    assign last_res  = (idx_reg == (head_job.cnt - 4'd1));
    assign pop       = load && last_res;
    assign cur_byte  = head_job.bytes[idx_reg];
    assign data_byte = strip_high_bit ? (cur_byte & wsee_pkg::STRIP_MASK) : cur_byte;

    always_comb begin
        tdata_next = '0;
        if (head_job.kind == wsee_pkg::KIND_WINDOW) begin
            // big-endian pairs: rows, cols, x pixels, y pixels
            for (int k = 0; k < 4; k++) begin
                tdata_next[8 + 16*k +: 16] = {head_job.bytes[2*k], head_job.bytes[2*k + 1]};
            end
        end else begin
            tdata_next[7:0] = data_byte;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (load) begin
                idx_reg       <= last_res ? '0 : idx_reg + 4'd1;
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            tdata_reg <= tdata_next;
            tuser_reg <= logic'(head_job.kind);
            tlast_reg <= last_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = tdata_reg;
    assign m_tuser  = tuser_reg;
    assign m_tlast  = tlast_reg;

endmodule

`default_nettype wire
